// File: rtl/ttce_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttce_pkg
// Shared types, codes and build defaults for the text terminal character
// engine.
// ----------------------------------------------------------------------------
package ttce_pkg;

  // build defaults
  localparam int MAX_COLS_DEF = 128;
  localparam int MAX_ROWS_DEF = 64;

  // stream and config port widths
  localparam int IN_DATA_W   = 24;  // char_code, read_col, read_row, zero fill
  localparam int IN_USER_W   = 2;   // action
  localparam int OUT_DATA_W  = 24;  // cursor_col, cursor_row, cursor_visible, cell_char
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 8;

  localparam int CHAR_W  = 7;
  localparam int BLINK_W = 6;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_COLUMNS = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ROWS    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_BLINK   = 2'd2;

  localparam logic [BLINK_W-1:0] BLINK_RESET = 6'd24;

  // character codes
  localparam logic [CHAR_W-1:0] SPACE_CHAR = 7'd32;
  localparam logic [7:0] CHAR_BS    = 8'd8;
  localparam logic [7:0] CHAR_TAB   = 8'd9;
  localparam logic [7:0] CHAR_LF    = 8'd10;
  localparam logic [7:0] CHAR_CR    = 8'd13;
  localparam logic [7:0] PRINT_LO   = 8'd32;
  localparam logic [7:0] PRINT_HI   = 8'd126;
  localparam int         TAB_SPACES = 4;

  typedef enum logic [1:0] {
    ACT_PUT   = 2'd0,
    ACT_CLEAR = 2'd1,
    ACT_TICK  = 2'd2,
    ACT_READ  = 2'd3
  } action_t;

endpackage

// File: rtl/ttce_cell_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttce_cell_store
// Character cell memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ttce_cell_store #(
  parameter int ADDR_W = 13,
  parameter int DEPTH  = 8192,
  parameter int DATA_W = 7
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/text_terminal_char_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_terminal_char_engine
// Character-cell text terminal: put, clear, blink tick and cell read on a
// cell memory with one write and one read port under a small sequencer.
// ----------------------------------------------------------------------------
// Timing: each transfer is accepted in idle and then executed on the cell
// memory; s_tready stays low until the sequencer is idle again. A tab stores
// four spaces. A line feed or wrap at the bottom row scrolls by reading each
// cell and writing it one row up, then blanks the last row. Clear sweeps all
// MAX_ROWS * 2^clog2(MAX_COLS) cells (8192 at the defaults); the same sweep
// runs after reset, during which s_tready stays low (config writes are taken).
// A result waiting on m_tready holds the next item in its done state.
// ----------------------------------------------------------------------------
module text_terminal_char_engine #(
  parameter int MAX_COLS = ttce_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = ttce_pkg::MAX_ROWS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // config write channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ttce_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ttce_pkg::CFG_DATA_W-1:0]  cfg_data,
  // input stream
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [ttce_pkg::IN_DATA_W-1:0]   s_tdata,  // char_code, read_col, read_row
  input  logic [ttce_pkg::IN_USER_W-1:0]   s_tuser,  // action
  // result stream
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [ttce_pkg::OUT_DATA_W-1:0]  m_tdata   // cursor_col, cursor_row,
                                                     // cursor_visible, cell_char
);

  import ttce_pkg::*;

  localparam int COL_W  = $clog2(MAX_COLS);
  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int ADDR_W = COL_W + ROW_W;
  localparam int DEPTH  = MAX_ROWS * (1 << COL_W);
  localparam int AC_W   = $clog2(MAX_COLS + 1);
  localparam int AR_W   = $clog2(MAX_ROWS + 1);

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_EXEC   = 8'b0000_0010,
    ST_PUTCH  = 8'b0000_0100,
    ST_SCR_RD = 8'b0000_1000,
    ST_SCR_WR = 8'b0001_0000,
    ST_BLANK  = 8'b0010_0000,
    ST_CLEAR  = 8'b0100_0000,
    ST_DONE   = 8'b1000_0000
  } state_t;

  state_t state, state_next;
  logic   init_clear, init_clear_next;

  logic [7:0]         columns_in_use;
  logic [6:0]         rows_in_use;
  logic [BLINK_W-1:0] blink_period;

  logic [COL_W-1:0]   cur_col, cur_col_next;
  logic [ROW_W-1:0]   cur_row, cur_row_next;
  logic [BLINK_W-1:0] blink_count, blink_count_next;
  logic               cursor_on, cursor_on_next;
  logic [1:0]         tab_left, tab_left_next;
  logic [COL_W-1:0]   sx, sx_next;
  logic [ROW_W-1:0]   sy, sy_next;
  logic [ADDR_W-1:0]  clr_addr, clr_addr_next;

  action_t    act_q;
  logic [7:0] code_q;
  logic       in_range_q;

  logic [AC_W-1:0] act_cols;
  logic [AR_W-1:0] act_rows;
  logic            size_zero;
  logic [COL_W:0]  col_inc;
  logic [ROW_W:0]  row_inc;
  logic [COL_W:0]  sx_inc;
  logic [ROW_W:0]  sy_inc;
  logic            col_wrap, row_wrap, sx_last, sy_last, rows_gt1;
  logic [ROW_W-1:0] last_row;
  logic [COL_W-1:0] bs_col;
  logic [BLINK_W-1:0] blink_inc;
  logic            is_tab, is_print;

  logic [7:0] in_char;
  logic [6:0] in_col;
  logic [5:0] in_row;
  logic       s_accept, cfg_wr, out_free;
  logic       in_range;

  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [CHAR_W-1:0] mem_wdata, mem_rdata;

  logic       nl_req, do_adv, put_cont, done_now, load_out;
  logic [1:0] rem;
  logic [CHAR_W-1:0] cell_val;
  logic [OUT_DATA_W-1:0] out_word;

  assign in_char = s_tdata[7:0];
  assign in_col  = s_tdata[14:8];
  assign in_row  = s_tdata[20:15];

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign s_accept  = s_tvalid && s_tready;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign out_free  = !m_tvalid || m_tready;

  assign act_cols  = (32'(columns_in_use) > MAX_COLS) ? AC_W'(MAX_COLS) : AC_W'(columns_in_use);
  assign act_rows  = (32'(rows_in_use) > MAX_ROWS) ? AR_W'(MAX_ROWS) : AR_W'(rows_in_use);
  assign size_zero = (act_cols == '0) || (act_rows == '0);
  assign rows_gt1  = (32'(act_rows) > 1);
  assign last_row  = ROW_W'(act_rows - AR_W'(1));

  assign col_inc  = {1'b0, cur_col} + (COL_W+1)'(1);
  assign row_inc  = {1'b0, cur_row} + (ROW_W+1)'(1);
  assign sx_inc   = {1'b0, sx} + (COL_W+1)'(1);
  assign sy_inc   = {1'b0, sy} + (ROW_W+1)'(1);
  assign col_wrap = (32'(col_inc) >= 32'(act_cols));
  assign row_wrap = (32'(row_inc) >= 32'(act_rows));
  assign sx_last  = (32'(sx_inc) == 32'(act_cols));
  assign sy_last  = (32'(sy_inc) == 32'(act_rows));
  assign bs_col   = cur_col - COL_W'(1);

  assign blink_inc = blink_count + BLINK_W'(1);
  assign is_tab    = (code_q == CHAR_TAB);
  assign is_print  = (code_q >= PRINT_LO) && (code_q <= PRINT_HI);

  assign in_range  = (32'(in_col) < 32'(act_cols)) && (32'(in_row) < 32'(act_rows));

  // read port: requested cell at accept, source cell during scroll
  assign mem_re    = s_accept || (state == ST_SCR_RD);
  assign mem_raddr = s_accept ? {ROW_W'(in_row), COL_W'(in_col)} : {sy, sx};

  ttce_cell_store #(
    .ADDR_W (ADDR_W),
    .DEPTH  (DEPTH),
    .DATA_W (CHAR_W)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_comb begin
    state_next       = state;
    init_clear_next  = init_clear;
    cur_col_next     = cur_col;
    cur_row_next     = cur_row;
    blink_count_next = blink_count;
    cursor_on_next   = cursor_on;
    tab_left_next    = tab_left;
    sx_next          = sx;
    sy_next          = sy;
    clr_addr_next    = clr_addr;
    mem_we           = 1'b0;
    mem_waddr        = {cur_row, cur_col};
    mem_wdata        = SPACE_CHAR;
    nl_req           = 1'b0;
    do_adv           = 1'b0;
    put_cont         = 1'b0;
    done_now         = 1'b0;
    load_out         = 1'b0;
    rem              = 2'd0;

    // size change homes the cursor and restarts the blink
    if (cfg_wr && (cfg_index == CFG_COLUMNS || cfg_index == CFG_ROWS)) begin
      cur_col_next     = '0;
      cur_row_next     = '0;
      blink_count_next = '0;
      cursor_on_next   = 1'b1;
    end

    case (state)
      ST_IDLE: begin
        if (s_accept) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (act_q)
          ACT_PUT: begin
            if (size_zero) begin
              done_now = 1'b1;
            end else if (code_q == CHAR_CR) begin
              cur_col_next = '0;
              done_now     = 1'b1;
            end else if (code_q == CHAR_LF) begin
              nl_req = 1'b1;
            end else if (code_q == CHAR_BS) begin
              if (cur_col != '0) begin
                cur_col_next = bs_col;
                mem_we       = 1'b1;
                mem_waddr    = {cur_row, bs_col};
              end
              done_now = 1'b1;
            end else if (is_tab || is_print) begin
              mem_we    = 1'b1;
              mem_wdata = is_tab ? SPACE_CHAR : code_q[CHAR_W-1:0];
              rem       = is_tab ? 2'(TAB_SPACES - 1) : 2'd0;
              do_adv    = 1'b1;
            end else begin
              done_now = 1'b1;
            end
          end
          ACT_CLEAR: begin
            cur_col_next  = '0;
            cur_row_next  = '0;
            clr_addr_next = '0;
            state_next    = ST_CLEAR;
          end
          ACT_TICK: begin
            if (blink_inc >= blink_period) begin
              blink_count_next = '0;
              cursor_on_next   = !cursor_on;
            end else begin
              blink_count_next = blink_inc;
            end
            done_now = 1'b1;
          end
          default: begin
            done_now = 1'b1;
          end
        endcase
      end
      ST_PUTCH: begin
        mem_we = 1'b1;
        rem    = tab_left;
        do_adv = 1'b1;
      end
      ST_SCR_RD: begin
        state_next = ST_SCR_WR;
      end
      ST_SCR_WR: begin
        mem_we    = 1'b1;
        mem_waddr = {ROW_W'(sy - ROW_W'(1)), sx};
        mem_wdata = mem_rdata;
        if (sx_last) begin
          sx_next = '0;
          if (sy_last) begin
            state_next = ST_BLANK;
          end else begin
            sy_next    = sy_inc[ROW_W-1:0];
            state_next = ST_SCR_RD;
          end
        end else begin
          sx_next    = sx_inc[COL_W-1:0];
          state_next = ST_SCR_RD;
        end
      end
      ST_BLANK: begin
        mem_we    = 1'b1;
        mem_waddr = {last_row, sx};
        if (sx_last) begin
          sx_next = '0;
          if (tab_left != 2'd0) begin
            tab_left_next = tab_left - 2'd1;
            state_next    = ST_PUTCH;
          end else begin
            done_now = 1'b1;
          end
        end else begin
          sx_next = sx_inc[COL_W-1:0];
        end
      end
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        if (clr_addr == ADDR_W'(DEPTH - 1)) begin
          if (init_clear) begin
            init_clear_next = 1'b0;
            state_next      = ST_IDLE;
          end else begin
            done_now = 1'b1;
          end
        end else begin
          clr_addr_next = clr_addr + ADDR_W'(1);
        end
      end
      ST_DONE: begin
        done_now = 1'b1;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    // cursor advance after a stored character
    if (do_adv) begin
      cur_col_next = col_inc[COL_W-1:0];
      if (col_wrap) begin
        nl_req = 1'b1;
      end else begin
        put_cont = 1'b1;
      end
    end

    // new line, scrolling at the bottom row
    if (nl_req) begin
      cur_col_next = '0;
      if (row_wrap) begin
        cur_row_next  = last_row;
        tab_left_next = rem;
        sx_next       = '0;
        sy_next       = ROW_W'(1);
        state_next    = rows_gt1 ? ST_SCR_RD : ST_BLANK;
      end else begin
        cur_row_next = row_inc[ROW_W-1:0];
        put_cont     = 1'b1;
      end
    end

    if (put_cont) begin
      if (rem != 2'd0) begin
        tab_left_next = rem - 2'd1;
        state_next    = ST_PUTCH;
      end else begin
        done_now = 1'b1;
      end
    end

    if (done_now) begin
      if (out_free) begin
        load_out   = 1'b1;
        state_next = ST_IDLE;
      end else begin
        state_next = ST_DONE;
      end
    end
  end

  assign cell_val = (act_q == ACT_READ && in_range_q) ? mem_rdata : SPACE_CHAR;
  assign out_word = {3'b000, cell_val, cursor_on_next, 6'(cur_row_next), 7'(cur_col_next)};

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_CLEAR;
      init_clear     <= 1'b1;
      clr_addr       <= '0;
      cur_col        <= '0;
      cur_row        <= '0;
      blink_count    <= '0;
      cursor_on      <= 1'b1;
      tab_left       <= '0;
      sx             <= '0;
      sy             <= '0;
      columns_in_use <= '0;
      rows_in_use    <= '0;
      blink_period   <= BLINK_RESET;
      m_tvalid       <= 1'b0;
    end else begin
      state       <= state_next;
      init_clear  <= init_clear_next;
      clr_addr    <= clr_addr_next;
      cur_col     <= cur_col_next;
      cur_row     <= cur_row_next;
      blink_count <= blink_count_next;
      cursor_on   <= cursor_on_next;
      tab_left    <= tab_left_next;
      sx          <= sx_next;
      sy          <= sy_next;
      if (cfg_wr) begin
        case (cfg_index)
          CFG_COLUMNS: columns_in_use <= cfg_data;
          CFG_ROWS:    rows_in_use    <= cfg_data[6:0];
          CFG_BLINK:   blink_period   <= cfg_data[BLINK_W-1:0];
          default: ;
        endcase
      end
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      act_q      <= action_t'(s_tuser);
      code_q     <= in_char;
      in_range_q <= in_range;
    end
    if (load_out) begin
      m_tdata <= out_word;
    end
  end

endmodule

// File: rtl/ttce_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttce_checker
// Port-level checks for the text terminal character engine, bound to the top.
// ----------------------------------------------------------------------------
module ttce_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [ttce_pkg::OUT_DATA_W-1:0] m_tdata
);

  import ttce_pkg::*;

  // no result is left over from before reset
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // one item at a time: input closes after each transfer
  assert property (@(posedge clk) disable iff (rst) (s_tvalid && s_tready) |=> !s_tready)
    else $error("input still open after a transfer");

  // a new result only shows as the sequencer goes back to idle
  assert property (@(posedge clk) disable iff (rst) $rose(m_tvalid) |-> s_tready)
    else $error("result raised while still busy");

  // stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

  // top bits of the result are zero fill
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[OUT_DATA_W-1:21] == '0))
    else $error("result fill bits not zero");

endmodule

bind text_terminal_char_engine ttce_checker u_ttce_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// File: dv/text_terminal_char_engine_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_terminal_char_engine_chk
// Passive checker for the terminal engine. Tracks config writes and accepted
// items on its own copy of the screen, cursor and blink state, queues the
// status each item should return, and compares every result transfer field
// by field against the oldest queued status.
// ----------------------------------------------------------------------------
module text_terminal_char_engine_chk (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [ttce_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ttce_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             s_tvalid,
  input  logic                             s_tready,
  input  logic [ttce_pkg::IN_DATA_W-1:0]   s_tdata,
  input  logic [ttce_pkg::IN_USER_W-1:0]   s_tuser,
  input  logic                             m_tvalid,
  input  logic                             m_tready,
  input  logic [ttce_pkg::OUT_DATA_W-1:0]  m_tdata,
  output int                               mismatches,
  output int                               outstanding
);

  import ttce_pkg::*;

  localparam int COLS = MAX_COLS_DEF;
  localparam int ROWS = MAX_ROWS_DEF;

  // packed so that col lands in the low bits, as on m_tdata
  typedef struct packed {
    logic [CHAR_W-1:0] glyph;
    logic              visible;
    logic [5:0]        row;
    logic [6:0]        col;
  } term_status_t;

  logic [CHAR_W-1:0] screen [COLS*ROWS];
  int                cur_x, cur_y, blink_cnt;
  logic              cursor_on;
  int                cols_reg, rows_reg, blink_per;
  term_status_t      status_due [$];
  int                n_accepted, n_returned;
  term_status_t      got, want;

  assign outstanding = n_accepted - n_returned;

  function automatic int cols_active();
    return (cols_reg > COLS) ? COLS : cols_reg;
  endfunction

  function automatic int rows_active();
    return (rows_reg > ROWS) ? ROWS : rows_reg;
  endfunction

  function automatic void blank_screen();
    foreach (screen[i]) screen[i] = SPACE_CHAR;
  endfunction

  function automatic void restart_cursor();
    cur_x = 0;
    cur_y = 0;
    blink_cnt = 0;
    cursor_on = 1'b1;
  endfunction

  function automatic void scroll_screen();
    int nc, nr, x, y;
    nc = cols_active();
    nr = rows_active();
    if (nr == 0) return;
    for (y = 1; y < nr; y++)
      for (x = 0; x < nc; x++) screen[(y-1)*COLS + x] = screen[y*COLS + x];
    for (x = 0; x < nc; x++) screen[(nr-1)*COLS + x] = SPACE_CHAR;
    cur_y = nr - 1;
  endfunction

  function automatic void next_line();
    cur_x = 0;
    cur_y++;
    if (cur_y >= rows_active()) scroll_screen();
  endfunction

  function automatic void store_glyph(logic [CHAR_W-1:0] c);
    if (cur_x < COLS && cur_y < ROWS) screen[cur_y*COLS + cur_x] = c;
    cur_x++;
    if (cur_x >= cols_active()) next_line();
  endfunction

  function automatic void put_code(logic [7:0] code);
    int i;
    if (cols_active() == 0 || rows_active() == 0) return;
    if (code == CHAR_CR) begin
      cur_x = 0;
    end else if (code == CHAR_LF) begin
      next_line();
    end else if (code == CHAR_BS) begin
      if (cur_x > 0) begin
        cur_x--;
        screen[cur_y*COLS + cur_x] = SPACE_CHAR;
      end
    end else if (code == CHAR_TAB) begin
      for (i = 0; i < TAB_SPACES; i++) store_glyph(SPACE_CHAR);
    end else if (code >= PRINT_LO && code <= PRINT_HI) begin
      store_glyph(code[CHAR_W-1:0]);
    end
  endfunction

  function automatic term_status_t apply_action(action_t act, logic [IN_DATA_W-1:0] d);
    term_status_t s;
    int           rc, rr;
    rc = int'(d[14:8]);
    rr = int'(d[20:15]);
    s.glyph = SPACE_CHAR;
    case (act)
      ACT_PUT: put_code(d[7:0]);
      ACT_CLEAR: begin
        blank_screen();
        cur_x = 0;
        cur_y = 0;
      end
      ACT_TICK: begin
        blink_cnt = (blink_cnt + 1) % 64;
        if (blink_cnt >= blink_per) begin
          blink_cnt = 0;
          cursor_on = ~cursor_on;
        end
      end
      default: begin
        if (rc < cols_active() && rr < rows_active()) s.glyph = screen[rr*COLS + rc];
      end
    endcase
    s.col = cur_x[6:0];
    s.row = cur_y[5:0];
    s.visible = cursor_on;
    return s;
  endfunction

  function automatic void write_register(logic [CFG_INDEX_W-1:0] idx,
                                         logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_COLUMNS: begin
        cols_reg = int'(val);
        restart_cursor();
      end
      CFG_ROWS: begin
        rows_reg = int'(val[6:0]);
        restart_cursor();
      end
      CFG_BLINK: blink_per = int'(val[BLINK_W-1:0]);
      default: ;
    endcase
  endfunction

  function automatic void flag_result(string what, term_status_t exp_s, term_status_t act_s);
    mismatches++;
    if (mismatches <= 10)
      $display({"%0t %s: expected col %0d row %0d vis %0d cell %0d,",
                " got col %0d row %0d vis %0d cell %0d"},
               $realtime, what, exp_s.col, exp_s.row, exp_s.visible, exp_s.glyph,
               act_s.col, act_s.row, act_s.visible, act_s.glyph);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      blank_screen();
      restart_cursor();
      cols_reg = 0;
      rows_reg = 0;
      blink_per = int'(BLINK_RESET);
      status_due.delete();
      mismatches = 0;
      n_accepted <= 0;
      n_returned <= 0;
    end else begin
      if (cfg_valid && cfg_ready) write_register(cfg_index, cfg_data);
      if (m_tvalid && m_tready) begin
        got = term_status_t'(m_tdata[20:0]);
        n_returned <= n_returned + 1;
        if (status_due.size() == 0) begin
          flag_result("unexpected result", '0, got);
        end else begin
          want = status_due.pop_front();
          if (got.col !== want.col || got.row !== want.row ||
              got.visible !== want.visible || got.glyph !== want.glyph)
            flag_result("status mismatch", want, got);
        end
      end
      if (s_tvalid && s_tready) begin
        status_due.push_back(apply_action(action_t'(s_tuser), s_tdata));
        n_accepted <= n_accepted + 1;
      end
    end
  end

endmodule

// File: dv/text_terminal_char_engine_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_terminal_char_engine_tb
// Drives the terminal engine through a directed pass over control codes,
// wrap, scroll, blink and edge reads, then through phases of random traffic
// at many screen sizes and blink periods, with random stalls on both
// streams. Results are checked by the companion checker module.
// ----------------------------------------------------------------------------
module text_terminal_char_engine_tb;
  import ttce_pkg::*;

  localparam int LIMIT_CYCLES = 20_000_000;
  localparam int ITEM_TARGET  = 650;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_DATA_W-1:0]   s_tdata;   // char_code, read_col, read_row
  logic [IN_USER_W-1:0]   s_tuser;   // action
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  m_tdata;   // cursor_col, cursor_row, cursor_visible, cell_char

  int mismatches, outstanding;
  bit calm;
  int rx_hold = 0;
  int rx_pick;
  int wd_cycles;
  int items_sent, clears_left, scr_cols, scr_rows;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  text_terminal_char_engine dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  text_terminal_char_engine_chk chk (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  // result-side backpressure
  always @(posedge clk) begin
    if (calm) begin
      m_tready <= 1'b1;
    end else if (rx_hold > 0) begin
      m_tready <= 1'b0;
      rx_hold <= rx_hold - 1;
    end else begin
      rx_pick = $urandom_range(0, 99);
      if (rx_pick < 60) begin
        m_tready <= 1'b1;
      end else if (rx_pick < 92) begin
        m_tready <= 1'b0;
        rx_hold <= $urandom_range(0, 3);
      end else begin
        m_tready <= 1'b0;
        rx_hold <= $urandom_range(8, 40);
      end
    end
  end

  initial begin
    wd_cycles = 0;
    while (wd_cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      wd_cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

  function automatic int pick_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (calm || pick < 65) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] pick_size(int typical, int widest);
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) return 8'd0;
    if (pick < 20) return 8'($urandom_range(typical + 1, widest));
    return 8'($urandom_range(1, typical));
  endfunction

  // wait until every expected result has been returned
  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_COLUMNS) scr_cols = (val > 128) ? 128 : int'(val);
    if (idx == CFG_ROWS) scr_rows = (val[6:0] > 64) ? 64 : int'(val[6:0]);
  endtask

  task automatic push_item(action_t act, logic [7:0] code, logic [6:0] col, logic [5:0] row);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {3'b000, row, col, code};
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  task automatic random_item();
    int         pick;
    logic [7:0] code;
    logic [6:0] col;
    logic [5:0] row;
    pick = $urandom_range(0, 99);
    code = 8'($urandom);
    col  = 7'($urandom);
    row  = 6'($urandom);
    if (scr_cols > 0 && scr_rows > 0 && $urandom_range(0, 3) != 0) begin
      col = 7'($urandom_range(0, scr_cols - 1));
      row = 6'($urandom_range(0, scr_rows - 1));
    end
    if (pick < 45) push_item(ACT_PUT, 8'($urandom_range(PRINT_LO, PRINT_HI)), col, row);
    else if (pick < 52) push_item(ACT_PUT, CHAR_LF, col, row);
    else if (pick < 56) push_item(ACT_PUT, CHAR_CR, col, row);
    else if (pick < 60) push_item(ACT_PUT, CHAR_BS, col, row);
    else if (pick < 63) push_item(ACT_PUT, CHAR_TAB, col, row);
    else if (pick < 67) push_item(ACT_PUT, code, col, row);
    else if (pick < 78) push_item(ACT_TICK, code, col, row);
    else if (pick < 98) push_item(ACT_READ, code, col, row);
    else if (clears_left > 0) begin
      clears_left--;
      push_item(ACT_CLEAR, code, col, row);
    end else push_item(ACT_TICK, code, col, row);
  endtask

  initial begin
    int  n, lf_left, pause_at;
    bit  resized;
    rst       <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_COLUMNS;
    cfg_data  <= '0;
    s_tvalid  <= 1'b0;
    s_tuser   <= ACT_PUT;
    s_tdata   <= '0;
    calm = 1'b0;
    items_sent = 0;
    clears_left = 12;
    scr_cols = 0;
    scr_rows = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // zero size straight after reset: put does nothing, reads are blank
    push_item(ACT_PUT, 8'd65, 7'd0, 6'd0);
    push_item(ACT_READ, 8'd0, 7'd0, 6'd0);
    push_item(ACT_TICK, 8'd0, 7'd0, 6'd0);

    set_reg(CFG_COLUMNS, 8'd8);
    set_reg(CFG_ROWS, 8'd3);
    set_reg(CFG_BLINK, 8'd2);
    push_item(ACT_PUT, PRINT_LO, 7'd0, 6'd0);
    push_item(ACT_PUT, PRINT_HI, 7'd0, 6'd0);
    push_item(ACT_PUT, 8'd127, 7'd0, 6'd0);
    push_item(ACT_PUT, 8'd0, 7'd0, 6'd0);
    push_item(ACT_PUT, 8'd255, 7'd0, 6'd0);
    push_item(ACT_PUT, 8'd31, 7'd0, 6'd0);
    push_item(ACT_READ, 8'd0, 7'd1, 6'd0);
    push_item(ACT_PUT, CHAR_BS, 7'd0, 6'd0);
    push_item(ACT_PUT, CHAR_CR, 7'd0, 6'd0);
    push_item(ACT_PUT, CHAR_BS, 7'd0, 6'd0);
    push_item(ACT_PUT, CHAR_TAB, 7'd0, 6'd0);
    push_item(ACT_PUT, CHAR_TAB, 7'd0, 6'd0);
    push_item(ACT_PUT, CHAR_LF, 7'd0, 6'd0);
    push_item(ACT_PUT, CHAR_LF, 7'd0, 6'd0);
    push_item(ACT_READ, 8'd0, 7'd7, 6'd2);
    push_item(ACT_READ, 8'd0, 7'd127, 6'd63);
    push_item(ACT_READ, 8'd0, 7'd8, 6'd0);
    push_item(ACT_TICK, 8'd0, 7'd0, 6'd0);
    push_item(ACT_TICK, 8'd0, 7'd0, 6'd0);
    clears_left--;
    push_item(ACT_CLEAR, 8'd0, 7'd0, 6'd0);
    push_item(ACT_READ, 8'd0, 7'd0, 6'd0);

    // oversized registers saturate to the full screen; walk down and scroll
    set_reg(CFG_COLUMNS, 8'd255);
    set_reg(CFG_ROWS, 8'd127);
    set_reg(CFG_BLINK, 8'd63);
    lf_left = 66;
    for (int i = 0; i < 80; i++) begin
      n = $urandom_range(0, 99);
      if (n < 85 && lf_left > 0) begin
        lf_left--;
        push_item(ACT_PUT, CHAR_LF, 7'($urandom), 6'($urandom));
      end else if (n < 93) begin
        push_item(ACT_PUT, 8'($urandom_range(PRINT_LO, PRINT_HI)), 7'($urandom), 6'($urandom));
      end else begin
        push_item(ACT_READ, 8'($urandom), 7'($urandom), 6'($urandom));
      end
    end
    set_reg(CFG_COLUMNS, 8'd128);
    set_reg(CFG_ROWS, 8'd64);
    repeat (30) random_item();

    set_reg(CFG_COLUMNS, 8'd0);
    set_reg(CFG_ROWS, 8'd5);
    set_reg(CFG_BLINK, 8'd0);
    repeat (20) random_item();
    set_reg(CFG_COLUMNS, 8'd6);
    set_reg(CFG_ROWS, 8'd0);
    set_reg(CFG_SPARE, 8'($urandom));
    repeat (20) random_item();
    set_reg(CFG_COLUMNS, 8'd1);
    set_reg(CFG_ROWS, 8'd1);
    set_reg(CFG_BLINK, 8'd1);
    repeat (30) random_item();

    while (items_sent < ITEM_TARGET) begin
      calm = ($urandom_range(0, 3) == 0);
      resized = 1'b0;
      if ($urandom_range(0, 3) != 0) begin
        set_reg(CFG_COLUMNS, pick_size(20, 128));
        resized = 1'b1;
      end
      if ($urandom_range(0, 3) != 0) begin
        set_reg(CFG_ROWS, pick_size(10, 16));
        resized = 1'b1;
      end
      if ($urandom_range(0, 2) == 0) begin
        n = $urandom_range(0, 99);
        if (n < 15) set_reg(CFG_BLINK, 8'd0);
        else if (n < 25) set_reg(CFG_BLINK, 8'd1);
        else if (n < 35) set_reg(CFG_BLINK, 8'd63);
        else set_reg(CFG_BLINK, 8'($urandom_range(0, 63)));
      end
      if ($urandom_range(0, 6) == 0) set_reg(CFG_SPARE, 8'($urandom));
      if (resized && clears_left > 0 && $urandom_range(0, 2) == 0) begin
        clears_left--;
        push_item(ACT_CLEAR, 8'($urandom), 7'($urandom), 6'($urandom));
      end
      n = $urandom_range(30, 70);
      pause_at = $urandom_range(0, n - 1);
      for (int i = 0; i < n; i++) begin
        if (i == pause_at) settle();
        random_item();
      end
    end

    settle();
    repeat (50) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
